[rtl/core/mboxsplit_pkg.sv]
// Shared types, table states, symbols and transition functions of the mailbox splitter.
`default_nettype none
package mboxsplit_pkg;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_END,
      KIND_BND,
      KIND_NOM
   } kind_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data;
   } res_type;

   // Reading transition: first result, landing state, whether the symbol is held.
   typedef struct packed {
      res_type    res;
      logic [5:0] next;
      logic       grab;
   } step_type;

   // Queue word: result of the reading transition, then the non-reading chain.
   typedef struct packed {
      res_type    head;
      logic [5:0] chain;
      logic [8:0] held;
   } cmd_type;

   localparam logic [5:0]
      ST_0  = 6'd0,  ST_1  = 6'd1,  ST_2  = 6'd2,  ST_3  = 6'd3,  ST_4  = 6'd4,
      ST_5  = 6'd5,  ST_6  = 6'd6,  ST_7  = 6'd7,  ST_8  = 6'd8,  ST_9  = 6'd9,
      ST_10 = 6'd10, ST_11 = 6'd11, ST_12 = 6'd12, ST_13 = 6'd13, ST_14 = 6'd14,
      ST_15 = 6'd15, ST_16 = 6'd16, ST_17 = 6'd17, ST_18 = 6'd18, ST_19 = 6'd19,
      ST_20 = 6'd20, ST_21 = 6'd21, ST_22 = 6'd22, ST_23 = 6'd23, ST_24 = 6'd24,
      ST_25 = 6'd25, ST_26 = 6'd26, ST_27 = 6'd27, ST_28 = 6'd28, ST_29 = 6'd29,
      ST_30 = 6'd30, ST_31 = 6'd31, ST_32 = 6'd32, ST_33 = 6'd33, ST_34 = 6'd34,
      ST_35 = 6'd35, ST_36 = 6'd36, ST_37 = 6'd37, ST_38 = 6'd38, ST_39 = 6'd39,
      ST_40 = 6'd40, ST_41 = 6'd41, ST_42 = 6'd42, ST_43 = 6'd43;

   localparam logic [8:0] SYM_END = 9'h100;
   localparam logic [8:0] SYM_NL  = 9'h00a;
   localparam logic [8:0] SYM_SP  = 9'h020;
   localparam logic [8:0] SYM_GT  = 9'h03e;
   localparam logic [8:0] SYM_F   = 9'h046;
   localparam logic [8:0] SYM_R   = 9'h072;
   localparam logic [8:0] SYM_O   = 9'h06f;
   localparam logic [8:0] SYM_M   = 9'h06d;

   localparam res_type RES_NONE = '{valid: 1'b0, kind: KIND_DATA, data: 8'h00};

   function automatic res_type res_char(input logic [8:0] ch);
      res_type r;
      r.valid = 1'b1;
      r.kind  = KIND_DATA;
      r.data  = ch[7:0];
      return r;
   endfunction

   function automatic res_type res_code(input kind_type k);
      res_type r;
      r.valid = 1'b1;
      r.kind  = k;
      r.data  = 8'h00;
      return r;
   endfunction

   // A held end mark comes back out as an end-of-input result.
   function automatic res_type res_held(input logic [8:0] held);
      res_type r;
      r = held[8] ? res_code(KIND_END) : res_char(held);
      return r;
   endfunction

   function automatic step_type read_step(input logic [5:0] st, input logic [8:0] sym);
      step_type r;
      logic     is_end;
      r.res  = RES_NONE;
      r.next = st;
      r.grab = 1'b0;
      is_end = (sym == SYM_END);
      unique case (st) inside
         ST_0: begin
            if (sym == SYM_NL) r.next = ST_1;
            else if (is_end) begin r.next = ST_31; r.res = res_code(KIND_END); end
            else begin r.next = ST_0; r.res = res_char(sym); r.grab = 1'b1; end
         end
         ST_1: begin
            if (sym == SYM_F) r.next = ST_3;
            else if (is_end) begin r.next = ST_31; r.res = res_code(KIND_END); end
            else if (sym == SYM_GT) begin r.next = ST_22; r.res = res_char(SYM_NL); end
            else if (sym == SYM_NL) begin r.next = ST_1; r.res = res_char(SYM_NL); end
            else begin r.next = ST_2; r.res = res_char(SYM_NL); r.grab = 1'b1; end
         end
         ST_3, ST_6, ST_10, ST_15: begin
            if (st == ST_3 && sym == SYM_R) r.next = ST_6;
            else if (st == ST_6 && sym == SYM_O) r.next = ST_10;
            else if (st == ST_10 && sym == SYM_M) r.next = ST_15;
            else if (st == ST_15 && sym == SYM_SP) r.next = ST_21;
            else if (is_end) begin r.next = ST_31; r.res = res_code(KIND_END); end
            else begin
               r.res  = res_char(SYM_NL);
               r.grab = 1'b1;
               r.next = (st == ST_3) ? ST_4 : (st == ST_6) ? ST_7 :
                        (st == ST_10) ? ST_11 : ST_16;
            end
         end
         ST_21: begin
            if (sym == SYM_NL) begin r.next = ST_37; r.res = res_code(KIND_BND); end
            else if (is_end) begin r.next = ST_31; r.res = res_code(KIND_END); end
            else begin r.next = ST_21; r.grab = 1'b1; end
         end
         ST_22: begin
            if (sym == SYM_GT) begin r.next = ST_22; r.res = res_char(SYM_GT); end
            else if (sym == SYM_F) r.next = ST_23;
            else begin r.next = ST_2; r.res = res_char(SYM_GT); r.grab = 1'b1; end
         end
         ST_23, ST_24, ST_25, ST_26: begin
            if (st == ST_23 && sym == SYM_R) r.next = ST_24;
            else if (st == ST_24 && sym == SYM_O) r.next = ST_25;
            else if (st == ST_25 && sym == SYM_M) r.next = ST_26;
            else if (st == ST_26 && sym == SYM_SP) begin
               r.next = ST_27;
               r.res  = res_char(SYM_F);
            end else begin
               r.res  = res_char(SYM_GT);
               r.grab = 1'b1;
               r.next = (st == ST_23) ? ST_4 : (st == ST_24) ? ST_7 :
                        (st == ST_25) ? ST_11 : ST_16;
            end
         end
         ST_32, ST_33, ST_34, ST_35, ST_36: begin
            if (st == ST_32 && sym == SYM_R) r.next = ST_33;
            else if (st == ST_33 && sym == SYM_O) r.next = ST_34;
            else if (st == ST_34 && sym == SYM_M) r.next = ST_35;
            else if (st == ST_35 && sym == SYM_SP) r.next = ST_36;
            else if (st == ST_36 && sym == SYM_NL) r.next = ST_37;
            else if (is_end) begin r.next = ST_31; r.res = res_code(KIND_NOM); end
            else begin
               r.grab = 1'b1;
               r.next = (st == ST_36) ? ST_36 : ST_31;
            end
         end
         ST_37, ST_39: begin
            if (sym == SYM_F) r.next = (st == ST_37) ? ST_40 : ST_3;
            else if (is_end) begin r.next = ST_31; r.res = res_code(KIND_END); end
            else if (sym == SYM_GT) r.next = ST_22;
            else if (st == ST_39 && sym == SYM_NL) r.next = ST_1;
            else begin r.next = ST_2; r.grab = 1'b1; end
         end
         ST_40, ST_41, ST_42, ST_43: begin
            if (st == ST_40 && sym == SYM_R) r.next = ST_41;
            else if (st == ST_41 && sym == SYM_O) r.next = ST_42;
            else if (st == ST_42 && sym == SYM_M) r.next = ST_43;
            else if (st == ST_43 && sym == SYM_SP) r.next = ST_21;
            else if (is_end) begin r.next = ST_31; r.res = res_code(KIND_END); end
            else begin
               r.grab = 1'b1;
               r.next = (st == ST_40) ? ST_4 : (st == ST_41) ? ST_7 :
                        (st == ST_42) ? ST_11 : ST_16;
            end
         end
         default: begin
            // seeking the first From line; unknown codes behave the same
            if (sym == SYM_F) r.next = ST_32;
            else if (is_end) begin r.next = ST_31; r.res = res_code(KIND_NOM); end
            else begin r.next = ST_31; r.grab = 1'b1; end
         end
      endcase
      return r;
   endfunction

   // Result of one non-reading state (none for reading states).
   function automatic res_type chain_emit(input logic [5:0] st, input logic [8:0] held);
      res_type r;
      r = RES_NONE;
      unique case (st) inside
         ST_4, ST_7, ST_11, ST_16:               r = res_char(SYM_F);
         ST_8, ST_12, ST_17, ST_27:              r = res_char(SYM_R);
         ST_13, ST_18, ST_28:                    r = res_char(SYM_O);
         ST_19, ST_29:                           r = res_char(SYM_M);
         ST_30:                                  r = res_char(SYM_SP);
         ST_2, ST_5, ST_9, ST_14, ST_20:         r = res_held(held);
         default:                                r = RES_NONE;
      endcase
      return r;
   endfunction

   function automatic logic is_chain(input logic [5:0] st);
      res_type r;
      r = chain_emit(st, SYM_END);
      return r.valid;
   endfunction

   function automatic logic [5:0] chain_next(input logic [5:0] st);
      logic [5:0] n;
      unique case (st) inside
         ST_2, ST_5, ST_9, ST_14, ST_20:  n = ST_38;
         ST_30:                           n = ST_0;
         ST_4, ST_7, ST_8, ST_11, ST_12, ST_13, ST_16, ST_17, ST_18, ST_19,
         ST_27, ST_28, ST_29:             n = st + 6'd1;
         default:                         n = st;
      endcase
      return n;
   endfunction

   // Reading state in which a chain starting at st comes to rest.
   function automatic logic [5:0] chain_end(input logic [5:0] st, input logic [8:0] held);
      logic [5:0] n;
      unique case (st) inside
         ST_2, ST_4, ST_5, ST_7, ST_8, ST_9, ST_11, ST_12, ST_13, ST_14,
         ST_16, ST_17, ST_18, ST_19, ST_20:  n = (held == SYM_NL) ? ST_39 : ST_0;
         ST_27, ST_28, ST_29, ST_30:         n = ST_0;
         default:                            n = st;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

[rtl/core/mboxsplit_front.sv]
// Front end: takes input words, runs the reading transition and queues the work.
`default_nettype none
module mboxsplit_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_in_byte,
   input  wire logic                   req_end_of_input,
   input  wire logic                   q_full,
   output logic                        q_push,
   output mboxsplit_pkg::cmd_type      q_cmd
);
   import mboxsplit_pkg::*;

   logic [5:0] state_ff, state_in;
   logic [8:0] held_ff, held_in;
   logic [8:0] sym;
   logic       accept;
   step_type   step;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign sym       = req_end_of_input ? SYM_END : {1'b0, req_in_byte};

   always_comb begin
      step     = read_step(state_ff, sym);
      held_in  = step.grab ? sym : held_ff;
      state_in = chain_end(step.next, held_in);
      q_cmd.head  = step.res;
      q_cmd.chain = step.next;
      q_cmd.held  = held_in;
      // drop words that give no result
      q_push = accept && (step.res.valid || is_chain(step.next));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_31;
         held_ff  <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/mboxsplit_queue.sv]
// Short command queue between the front and back ends.
`default_nettype none
module mboxsplit_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  mboxsplit_pkg::cmd_type      push_cmd,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        not_empty,
   output mboxsplit_pkg::cmd_type      pop_cmd
);
   import mboxsplit_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type     mem [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   count_ff, count_in;

   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = mem[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/mboxsplit_back.sv]
// Back end: expands queued commands into result words, one per cycle while rsp_stall is low.
`default_nettype none
module mboxsplit_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_not_empty,
   input  mboxsplit_pkg::cmd_type      q_cmd,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic [1:0]                  rsp_kind,
   output logic                        rsp_last
);
   import mboxsplit_pkg::*;

   res_type    head_ff;
   logic [5:0] chain_ff;
   logic [8:0] held_ff;
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   kind_type   out_kind_ff;
   logic       out_last_ff;

   logic       busy, load;
   res_type    cur;
   logic       cur_last;

   assign busy  = head_ff.valid || is_chain(chain_ff);
   assign load  = !out_valid_ff || !rsp_stall;
   assign q_pop = !busy && q_not_empty;

   always_comb begin
      if (head_ff.valid) begin
         cur      = head_ff;
         cur_last = !is_chain(chain_ff);
      end else begin
         cur      = chain_emit(chain_ff, held_ff);
         cur_last = !is_chain(chain_next(chain_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= RES_NONE;
         chain_ff     <= ST_0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            head_ff  <= q_cmd.head;
            chain_ff <= q_cmd.chain;
            held_ff  <= q_cmd.held;
         end else if (busy && load) begin
            // advance past the word just issued
            if (head_ff.valid) head_ff.valid <= 1'b0;
            else chain_ff <= chain_next(chain_ff);
         end
         if (load) out_valid_ff <= busy;
      end
   end

   always_ff @(posedge clock) begin
      if (busy && load) begin
         out_byte_ff <= cur.data;
         out_kind_ff <= cur.kind;
         out_last_ff <= cur_last;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_last     = out_last_ff;

endmodule
`default_nettype wire

[rtl/core/mbox_message_splitter_core.sv]
// Mailbox message splitter: top level joining front end, command queue and back end.
`default_nettype none
// Splits a mailbox byte stream into messages. Each input word carries a byte or the
// end-of-input mark and gives zero to six result words (data byte, end of input,
// message boundary, or no message found), the final one of them flagged by rsp_last.
// The front end takes one input word per cycle while the command queue has room; the
// back end issues one result word per cycle while rsp_stall is low, but it loads the
// next command only once every result of the current one is issued, and words that
// give no result are never queued. Input stalls only when QUEUE_DEPTH commands are
// waiting.
module mbox_message_splitter_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_input,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_kind,
   output logic            rsp_last
);
   import mboxsplit_pkg::*;

   logic    q_push, q_full, q_pop, q_not_empty;
   cmd_type push_cmd, pop_cmd;

   mboxsplit_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (push_cmd)
   );

   mboxsplit_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_cmd   (pop_cmd)
   );

   mboxsplit_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_not_empty  (q_not_empty),
      .q_cmd        (pop_cmd),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_last     (rsp_last)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command queue written while full");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("command queue read while empty");

   a_final_kinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_BND || rsp_kind == KIND_NOM)) |-> rsp_last)
      else $error("boundary or no-message word not flagged last");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
